FILE: rtl/core/spcmg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcmg_pkg
// Shared widths, controller states and the command and status groups that
// pass between the sieve controller and its datapath.
// ----------------------------------------------------------------------------
package spcmg_pkg;

	localparam int AddrW    = 16;
	localparam int MemDepth = 1 << AddrW;
	// sieving stops once p*p passes the limit, so p never exceeds 2^(AddrW/2)
	localparam int PrimeW   = AddrW / 2 + 1;
	localparam int SqW      = AddrW + 1;
	localparam int IdxW     = AddrW + 1;

	localparam logic [AddrW-1:0] FirstPrime = AddrW'(2);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FILL,
		S_PRIME_RD,
		S_PRIME_CHK,
		S_MARK,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic fill_wr;
		logic prime_init;
		logic prime_rd;
		logic prime_next;
		logic mark_init;
		logic mark_wr;
		logic scan_init;
		logic scan_rd;
		logic result_load;
	} dp_cmd_t;

	typedef struct packed {
		logic lim_small;
		logic fill_last;
		logic sq_over;
		logic rd_bit;
		logic idx_over;
		logic scan_last;
	} dp_sts_t;

endpackage

FILE: rtl/core/spcmg_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcmg_dpath
// Candidate bitmap, sieve counters and the prime count / gap accumulators.
// ----------------------------------------------------------------------------
module spcmg_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [15:0]                  limit,
	input  spcmg_pkg::dp_cmd_t           cmd,
	output spcmg_pkg::dp_sts_t           sts,
	output logic [15:0]                  prime_count,
	output logic [15:0]                  max_gap
);
	import spcmg_pkg::*;

	logic              bitmap_q [MemDepth];
	logic              mem_we;
	logic [AddrW-1:0]  mem_waddr;
	logic              mem_wdata;
	logic [AddrW-1:0]  mem_raddr;
	logic              rd_bit_q;

	logic [AddrW-1:0]  lim_q;
	logic [AddrW-1:0]  addr_q;
	logic [PrimeW-1:0] p_q;
	logic [SqW-1:0]    sq_q;
	logic [IdxW-1:0]   idx_q;

	logic              scan_vld_s1;
	logic [AddrW-1:0]  scan_addr_s1;
	logic [15:0]       count_q;
	logic [15:0]       gap_q;
	logic [AddrW-1:0]  last_q;
	logic [15:0]       diff;
	logic [15:0]       prime_count_q;
	logic [15:0]       max_gap_q;

	always_comb begin
		mem_we    = cmd.fill_wr | cmd.mark_wr;
		mem_waddr = cmd.fill_wr ? addr_q : idx_q[AddrW-1:0];
		// 0 and 1 go in as non-prime during the fill
		mem_wdata = cmd.fill_wr & (addr_q >= FirstPrime);
		mem_raddr = cmd.scan_rd ? addr_q : AddrW'(p_q);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bitmap_q[mem_waddr] <= mem_wdata;
		end
		if (cmd.prime_rd || cmd.scan_rd) begin
			rd_bit_q <= bitmap_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.scan_rd;
		end
	end

	assign diff = 16'(scan_addr_s1 - last_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lim_q  <= limit;
			addr_q <= '0;
		end
		if (cmd.fill_wr) begin
			addr_q <= addr_q + AddrW'(1);
		end
		if (cmd.prime_init) begin
			p_q  <= PrimeW'(FirstPrime);
			sq_q <= SqW'(FirstPrime) * SqW'(FirstPrime);
		end
		if (cmd.prime_next) begin
			// (p+1)^2 = p^2 + 2p + 1
			p_q  <= p_q + PrimeW'(1);
			sq_q <= sq_q + SqW'({p_q, 1'b1});
		end
		if (cmd.mark_init) begin
			idx_q <= IdxW'(sq_q);
		end
		if (cmd.mark_wr) begin
			idx_q <= idx_q + IdxW'(p_q);
		end
		if (cmd.scan_init) begin
			addr_q  <= FirstPrime;
			count_q <= '0;
			gap_q   <= '0;
			last_q  <= FirstPrime;
		end
		if (cmd.scan_rd) begin
			addr_q       <= addr_q + AddrW'(1);
			scan_addr_s1 <= addr_q;
		end
		if (scan_vld_s1 && rd_bit_q) begin
			count_q <= count_q + 16'(1);
			if (diff > gap_q) begin
				gap_q <= diff;
			end
			last_q <= scan_addr_s1;
		end
		if (cmd.result_load) begin
			prime_count_q <= sts.lim_small ? '0 : count_q;
			max_gap_q     <= sts.lim_small ? '0 : gap_q;
		end
	end

	always_comb begin
		sts.lim_small = (lim_q < FirstPrime);
		sts.fill_last = (addr_q == lim_q);
		sts.sq_over   = (sq_q > SqW'(lim_q));
		sts.rd_bit    = rd_bit_q;
		sts.idx_over  = (idx_q > IdxW'(lim_q));
		sts.scan_last = (addr_q == lim_q);
	end

	assign prime_count = prime_count_q;
	assign max_gap     = max_gap_q;

endmodule

FILE: rtl/core/spcmg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcmg_ctrl
// Sequencer for fill, sieve marking and bitmap scan; owns both handshakes.
// ----------------------------------------------------------------------------
module spcmg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  spcmg_pkg::dp_sts_t   sts,
	output spcmg_pkg::dp_cmd_t   cmd
);
	import spcmg_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.result_load || (out_valid_q && !out_ready);
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_FILL;
				end
			end
			S_FILL: begin
				if (sts.lim_small) begin
					state_d = S_DONE;
				end else begin
					cmd.fill_wr = 1'b1;
					if (sts.fill_last) begin
						cmd.prime_init = 1'b1;
						state_d        = S_PRIME_RD;
					end
				end
			end
			S_PRIME_RD: begin
				cmd.prime_rd = 1'b1;
				state_d      = S_PRIME_CHK;
			end
			S_PRIME_CHK: begin
				priority if (sts.sq_over) begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end else if (sts.rd_bit) begin
					// still marked: strike multiples from p*p on
					cmd.mark_init = 1'b1;
					state_d       = S_MARK;
				end else begin
					cmd.prime_next = 1'b1;
					state_d        = S_PRIME_RD;
				end
			end
			S_MARK: begin
				if (sts.idx_over) begin
					cmd.prime_next = 1'b1;
					state_d        = S_PRIME_RD;
				end else begin
					cmd.mark_wr = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// last read is folded into the totals here
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.result_load = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/sieve_prime_count_max_gap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sieve_prime_count_max_gap_core
// Sieve of Eratosthenes over a one-bit-per-number memory: counts the primes
// up to a limit and reports the largest gap between consecutive primes.
// ----------------------------------------------------------------------------
// One request at a time. A limit L of 2 or more goes through a fill of the
// bitmap from 0 to L, a read and a check per candidate p with p*p <= L, a
// write per multiple struck from p*p up to L for each prime such p, then a
// scan from 2 to L. All of these steps share the 64K x 1 bitmap, which the
// sequencer uses for one access at a time. Limits 0 and 1 skip the sieve
// and return zeros.
// The result sits in an output register, so a new request is taken once the
// sequencer is back in idle even while the previous result waits.
module sieve_prime_count_max_gap_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] limit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] prime_count,
	output logic [15:0] max_gap
);
	import spcmg_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	spcmg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	spcmg_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.limit       (limit),
		.cmd         (cmd),
		.sts         (sts),
		.prime_count (prime_count),
		.max_gap     (max_gap)
	);

endmodule

FILE: rtl/core/spcmg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcmg_checker
// Port-level checks for the sieve core, bound to the top level.
// ----------------------------------------------------------------------------
module spcmg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] prime_count,
	input logic [15:0] max_gap
);

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prime_count) && $stable(max_gap))
		else $error("result changed while stalled");

	// the sieve is not ready again in the cycle after it takes a request
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while sieve still busy");

	// a gap needs two primes
	a_gap_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (prime_count == 16'd0 || prime_count == 16'd1) |-> max_gap == 16'd0)
		else $error("nonzero gap with fewer than two primes");

endmodule

bind sieve_prime_count_max_gap_core spcmg_checker u_spcmg_checker (.*);

FILE: test/sieve_prime_count_max_gap_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sieve_prime_count_max_gap_core_tb
// Sends limits to the sieve core and checks every returned prime count and
// largest prime gap against a sieve computed inside the bench. Directed
// limits come first, then a pause until all results are back, then random
// limits, mostly small, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module sieve_prime_count_max_gap_core_tb;

	localparam int RandomLimits = 80;
	localparam int QuietTail    = 15;

	typedef struct packed {
		logic [15:0] limit;
		logic [15:0] prime_count;
		logic [15:0] max_gap;
	} sieve_result_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [15:0] limit       = 16'd0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [15:0] prime_count;
	logic [15:0] max_gap;

	logic [15:0]   pending_limits[$];
	sieve_result_t expected_results[$];
	bit            composite_map[0:65535];

	int            total_requests;
	int            sent_cnt     = 0;
	int            rcvd_cnt     = 0;
	int            mismatch_cnt = 0;
	int            send_idle    = 0;
	int            recv_stall   = 0;
	sieve_result_t predicted;
	sieve_result_t oldest;

	sieve_prime_count_max_gap_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.limit      (limit),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.prime_count(prime_count),
		.max_gap    (max_gap)
	);

	always #5 clk = ~clk;

	// sieve up to lim, then count the primes and track the widest gap from 2
	function automatic sieve_result_t count_primes_to(input logic [15:0] lim);
		sieve_result_t res;
		int            top;
		int            n;
		int            m;
		int            cnt;
		int            widest;
		int            prev;
		top        = int'(lim);
		res.limit  = lim;
		cnt        = 0;
		widest     = 0;
		prev       = 2;
		if (top >= 2) begin
			for (n = 0; n <= top; n++)
				composite_map[n] = 1'b0;
			for (n = 2; n <= top; n++) begin
				if (!composite_map[n]) begin
					for (m = n + n; m <= top; m += n)
						composite_map[m] = 1'b1;
				end
			end
			for (n = 2; n <= top; n++) begin
				if (!composite_map[n]) begin
					cnt++;
					if (n - prev > widest)
						widest = n - prev;
					prev = n;
				end
			end
		end
		res.prime_count = (cnt > 65535) ? 16'hFFFF : 16'(cnt);
		res.max_gap     = (widest > 65535) ? 16'hFFFF : 16'(widest);
		return res;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			limit     <= 16'd0;
			send_idle <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predicted = count_primes_to(limit);
				expected_results.push_back(predicted);
				sent_cnt <= sent_cnt + 1;
			end
			if (!in_valid || in_ready) begin
				if (send_idle > 0) begin
					send_idle <= send_idle - 1;
					in_valid  <= 1'b0;
				end else if (pending_limits.size() == 0) begin
					in_valid <= 1'b0;
				end else if (sent_cnt < total_requests - QuietTail &&
						$urandom_range(0, 4) == 0) begin
					send_idle <= $urandom_range(1, 14) - 1;
					in_valid  <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					limit    <= pending_limits.pop_front();
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				rcvd_cnt <= rcvd_cnt + 1;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, got count %0d gap %0d",
						$time, prime_count, max_gap);
					mismatch_cnt++;
				end else begin
					oldest = expected_results.pop_front();
					if (prime_count !== oldest.prime_count) begin
						$display("%0t: prime_count for limit %0d: expected %0d, got %0d",
							$time, oldest.limit, oldest.prime_count, prime_count);
						mismatch_cnt++;
					end
					if (max_gap !== oldest.max_gap) begin
						$display("%0t: max_gap for limit %0d: expected %0d, got %0d",
							$time, oldest.limit, oldest.max_gap, max_gap);
						mismatch_cnt++;
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				out_ready  <= 1'b0;
			end else if (rcvd_cnt < total_requests - QuietTail &&
					$urandom_range(0, 7) == 0) begin
				recv_stall <= $urandom_range(1, 14) - 1;
				out_ready  <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [15:0] directed[];
		int bucket;
		int big_left;
		directed = '{
			16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd8, 16'd9,
			16'd11, 16'd23, 16'd24, 16'd25, 16'd49, 16'd89, 16'd97, 16'd113,
			16'd127, 16'd128, 16'd1327, 16'd1361, 16'hFFFF
		};
		big_left       = 1;
		total_requests = directed.size() + RandomLimits;
		foreach (directed[i])
			pending_limits.push_back(directed[i]);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// let everything drain before the random part starts
		@(negedge clk);
		while (pending_limits.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);

		for (int k = 0; k < RandomLimits; k++) begin
			bucket = $urandom_range(0, 99);
			if (bucket < 68)
				pending_limits.push_back(16'($urandom_range(2, 400)));
			else if (bucket < 88)
				pending_limits.push_back(16'($urandom_range(401, 4000)));
			else if (bucket < 97 || big_left == 0)
				pending_limits.push_back(16'($urandom_range(0, 16)));
			else begin
				big_left--;
				pending_limits.push_back(16'($urandom_range(4001, 65535)));
			end
		end

		@(negedge clk);
		while (pending_limits.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (50) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/spcmg_pkg.sv
rtl/core/spcmg_dpath.sv
rtl/core/spcmg_ctrl.sv
rtl/core/sieve_prime_count_max_gap_core.sv
rtl/core/spcmg_checker.sv
test/sieve_prime_count_max_gap_core_tb.sv
